/* src/assert_macros.svh */
// Assertion macros shared by the clusterer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define SCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a property in the following cycle.
`define SCL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

/* src/scl_pkg.sv */
// Types and constants shared by the scan range clusterer modules.
`default_nettype none

package scl_pkg;

    // Scan geometry.
    localparam int MAX_SAMPLES = 1024;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int LEN_W       = IDX_W + 1;
    localparam logic [IDX_W-1:0] SAMPLE_LAST = IDX_W'(MAX_SAMPLES - 1);

    // Field widths.
    localparam int RANGE_W = 16;
    localparam int COS_W   = 17;
    localparam int THR_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_INC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 2'd3;

    // Register reset values.
    localparam logic [COS_W-1:0] COS_INC_RST  = 17'd65526;
    localparam logic [THR_W-1:0] GAP_THR_RST  = 16'd122;
    localparam logic [LEN_W-1:0] MIN_SIZE_RST = 11'd4;
    localparam logic [LEN_W-1:0] MAX_SIZE_RST = 11'd180;

    // Command queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One input sample.
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               last_sample;
    } sample_t;

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0] cluster_start;
        logic [LEN_W-1:0] cluster_length;
        logic             cluster_valid;
        logic             scan_done;
    } result_t;

    // Configuration register set.
    typedef struct packed {
        logic [COS_W-1:0] cos_increment_q16;
        logic [THR_W-1:0] gap_threshold_mm;
        logic [LEN_W-1:0] min_cluster_size;
        logic [LEN_W-1:0] max_cluster_size;
    } cfg_t;

    // Command from the front part: a candidate cluster or the end marker.
    typedef struct packed {
        logic             is_end;
        logic [IDX_W-1:0] start;
        logic [LEN_W-1:0] len;
    } cmd_t;

endpackage

`default_nettype wire

/* src/scl_cmd_fifo.sv */
// Short command queue that decouples the front and back parts.
`default_nettype none

`include "assert_macros.svh"

module scl_cmd_fifo
    import scl_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic push,
    input  wire  cmd_t push_data,
    output logic       full,
    input  wire  logic pop,
    output cmd_t       pop_data,
    output logic       empty
);

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SCL_ASSERT(a_fifo_no_overflow, !(push && full), "command pushed into a full queue")
    `SCL_ASSERT(a_fifo_count_bound, count_reg <= FIFO_CNT_W'(FIFO_DEPTH), "queue count too large")
    `SCL_ASSERT(a_fifo_ptr_gap, (rd_ptr_reg + FIFO_PTR_W'(count_reg)) == wr_ptr_reg,
                "queue pointers disagree with count")

endmodule

`default_nettype wire

/* src/scl_front.sv */
// Front part: accepts samples, runs the gap tests and queues cluster commands.
`default_nettype none

`include "assert_macros.svh"

module scl_front
    import scl_pkg::*;
(
    input  wire  logic    clk,
    input  wire  logic    rst_n,
    input  wire  cfg_t    cfg,
    input  wire  logic    sample_valid,
    output logic          sample_stall,
    input  wire  sample_t sample,
    output logic          push,
    output cmd_t          push_cmd,
    input  wire  logic    fifo_full
);

    typedef enum logic [6:0] {
        F_IDLE   = 7'b0000001,
        F_TEST1  = 7'b0000010,
        F_BREAK  = 7'b0000100,
        F_TEST2  = 7'b0001000,
        F_WRAP_A = 7'b0010000,
        F_WRAP_B = 7'b0100000,
        F_END    = 7'b1000000
    } fstate_t;

    localparam logic [2:0] STEP_DONE = 3'd7;

    fstate_t              state_reg, state_next;
    logic [2:0]           step_reg, step_next;
    logic [RANGE_W-1:0]   r_reg, r_next;
    logic                 last_reg, last_next;
    logic [RANGE_W-1:0]   prev_reg, prev_next;
    logic [RANGE_W-1:0]   first_range_reg, first_range_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic [IDX_W-1:0]     open_start_reg, open_start_next;
    logic [LEN_W-1:0]     open_length_reg, open_length_next;
    logic [LEN_W-1:0]     first_length_reg, first_length_next;
    logic                 first_closed_reg, first_closed_next;
    logic                 join2_reg, join2_next;

    // Gap test datapath.
    logic [RANGE_W-1:0]   op_x;
    logic [RANGE_W-1:0]   op_y;
    logic [COS_W-1:0]     mul_a;
    logic [RANGE_W-1:0]   mul_b;
    logic [32:0]          p_reg, p_next;
    logic [33:0]          l_acc_reg, l_acc_next;
    logic [31:0]          ab_reg, ab_next;
    logic [50:0]          r_acc_reg, r_acc_next;
    logic                 join_now;
    logic                 is_last;

    assign sample_stall = (state_reg != F_IDLE);
    assign is_last      = sample.last_sample || (index_reg == SAMPLE_LAST);

    // The first test compares with the previous sample, the wrap test with the first.
    assign op_x = (state_reg == F_TEST2) ? r_reg : prev_reg;
    assign op_y = (state_reg == F_TEST2) ? first_range_reg : r_reg;

    // Joined when (x*x + y*y) * 2^16 <= thr*thr * 2^16 + 2*cos*x*y.
    assign join_now = ({1'b0, l_acc_reg, 16'b0} <= r_acc_reg);

    // Shared multiplier: one product per step, registered.
    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin mul_a = {1'b0, op_x}; mul_b = op_x; end
            3'd1:    begin mul_a = {1'b0, op_y}; mul_b = op_y; end
            3'd2:    begin mul_a = {1'b0, op_x}; mul_b = op_y; end
            3'd3:    begin mul_a = {1'b0, cfg.gap_threshold_mm}; mul_b = cfg.gap_threshold_mm; end
            3'd4:    begin mul_a = cfg.cos_increment_q16; mul_b = ab_reg[15:0]; end
            3'd5:    begin mul_a = cfg.cos_increment_q16; mul_b = ab_reg[31:16]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        p_next = {16'b0, mul_a} * {17'b0, mul_b};
    end

    // Accumulation of both sides of the gap test, one product behind the multiplier.
    always_comb
    begin
        l_acc_next = l_acc_reg;
        ab_next    = ab_reg;
        r_acc_next = r_acc_reg;
        unique case (step_reg)
            3'd1:    l_acc_next = {1'b0, p_reg};
            3'd2:    l_acc_next = l_acc_reg + {1'b0, p_reg};
            3'd3:    ab_next = p_reg[31:0];
            3'd4:    r_acc_next = {3'b0, p_reg[31:0], 16'b0};
            3'd5:    r_acc_next = r_acc_reg + {17'b0, p_reg, 1'b0};
            3'd6:    r_acc_next = r_acc_reg + {1'b0, p_reg, 17'b0};
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        l_acc_reg <= l_acc_next;
        ab_reg    <= ab_next;
        r_acc_reg <= r_acc_next;
    end

    // Scan sequencer.
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        r_next            = r_reg;
        last_next         = last_reg;
        prev_next         = prev_reg;
        first_range_next  = first_range_reg;
        index_next        = index_reg;
        open_start_next   = open_start_reg;
        open_length_next  = open_length_reg;
        first_length_next = first_length_reg;
        first_closed_next = first_closed_reg;
        join2_next        = join2_reg;
        push              = 1'b0;
        push_cmd          = '0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (sample_valid)
                begin
                    r_next    = sample.range_mm;
                    last_next = is_last;
                    step_next = '0;
                    if (index_reg == '0)
                    begin
                        // The first sample opens the first cluster.
                        first_range_next  = sample.range_mm;
                        prev_next         = sample.range_mm;
                        open_start_next   = '0;
                        open_length_next  = LEN_W'(1);
                        first_length_next = '0;
                        first_closed_next = 1'b0;
                        if (is_last)
                        begin
                            state_next = F_TEST2;
                        end
                        else
                        begin
                            index_next = index_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = F_TEST1;
                    end
                end
            end

            F_TEST1:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_DONE)
                begin
                    step_next = '0;
                    prev_next = r_reg;
                    if (!join_now && first_closed_reg)
                    begin
                        state_next = F_BREAK;
                    end
                    else
                    begin
                        if (join_now)
                        begin
                            open_length_next = open_length_reg + 1'b1;
                        end
                        else
                        begin
                            // The first break closes the held-back first cluster.
                            first_length_next = open_length_reg;
                            first_closed_next = 1'b1;
                            open_start_next   = index_reg;
                            open_length_next  = LEN_W'(1);
                        end
                        if (last_reg)
                        begin
                            state_next = F_TEST2;
                        end
                        else
                        begin
                            state_next = F_IDLE;
                            index_next = index_reg + 1'b1;
                        end
                    end
                end
            end

            F_BREAK:
            begin
                if (!fifo_full)
                begin
                    push            = 1'b1;
                    push_cmd.start  = open_start_reg;
                    push_cmd.len    = open_length_reg;
                    open_start_next = index_reg;
                    open_length_next = LEN_W'(1);
                    if (last_reg)
                    begin
                        state_next = F_TEST2;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                        index_next = index_reg + 1'b1;
                    end
                end
            end

            F_TEST2:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_DONE)
                begin
                    step_next  = '0;
                    join2_next = join_now;
                    if (join_now && !first_closed_reg)
                    begin
                        state_next = F_END;
                    end
                    else
                    begin
                        state_next = F_WRAP_A;
                    end
                end
            end

            F_WRAP_A:
            begin
                // The last cluster, merged with the first one when the scan wraps closed.
                if (!fifo_full)
                begin
                    push           = 1'b1;
                    push_cmd.start = open_start_reg;
                    push_cmd.len   = join2_reg ? open_length_reg + first_length_reg
                                               : open_length_reg;
                    if (!join2_reg && first_closed_reg)
                    begin
                        state_next = F_WRAP_B;
                    end
                    else
                    begin
                        state_next = F_END;
                    end
                end
            end

            F_WRAP_B:
            begin
                if (!fifo_full)
                begin
                    push           = 1'b1;
                    push_cmd.start = '0;
                    push_cmd.len   = first_length_reg;
                    state_next     = F_END;
                end
            end

            F_END:
            begin
                if (!fifo_full)
                begin
                    push              = 1'b1;
                    push_cmd.is_end   = 1'b1;
                    prev_next         = '0;
                    first_range_next  = '0;
                    index_next        = '0;
                    open_start_next   = '0;
                    open_length_next  = '0;
                    first_length_next = '0;
                    first_closed_next = 1'b0;
                    state_next        = F_IDLE;
                end
            end

            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= F_IDLE;
            step_reg         <= '0;
            prev_reg         <= '0;
            first_range_reg  <= '0;
            index_reg        <= '0;
            open_start_reg   <= '0;
            open_length_reg  <= '0;
            first_length_reg <= '0;
            first_closed_reg <= 1'b0;
            join2_reg        <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            prev_reg         <= prev_next;
            first_range_reg  <= first_range_next;
            index_reg        <= index_next;
            open_start_reg   <= open_start_next;
            open_length_reg  <= open_length_next;
            first_length_reg <= first_length_next;
            first_closed_reg <= first_closed_next;
            join2_reg        <= join2_next;
            last_reg         <= last_next;
        end
    end

    // The sample register is payload.
    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    `SCL_ASSERT(a_front_open_nonempty, (index_reg == '0) || (open_length_reg != '0),
                "open cluster is empty in the middle of a scan")
    `SCL_ASSERT_NEXT(a_front_end_clears, push && push_cmd.is_end,
                     (index_reg == '0) && !first_closed_reg,
                     "scan state not cleared after the end marker")

endmodule

`default_nettype wire

/* src/scl_back.sv */
// Back part: applies the size filter and drives the result register.
`default_nettype none

`include "assert_macros.svh"

module scl_back
    import scl_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  cfg_t cfg,
    input  wire  logic fifo_empty,
    input  wire  cmd_t head,
    output logic       pop,
    output logic       result_valid,
    input  wire  logic result_stall,
    output result_t    result
);

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    size_ok;
    logic    load;

    assign size_ok = head.is_end ||
                     ((head.len >= cfg.min_cluster_size) && (head.len < cfg.max_cluster_size));

    // Take a command whenever the result register is free or being transferred.
    assign pop  = !fifo_empty && (!out_valid_reg || !result_stall);
    assign load = pop && size_ok;

    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next          = 1'b1;
            out_next.cluster_start  = head.is_end ? '0 : head.start;
            out_next.cluster_length = head.is_end ? '0 : head.len;
            out_next.cluster_valid  = !head.is_end;
            out_next.scan_done      = head.is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `SCL_ASSERT(a_back_marker_fields,
                !(result_valid && result.scan_done) ||
                (!result.cluster_valid && (result.cluster_length == '0)),
                "end marker carries cluster fields")

endmodule

`default_nettype wire

/* src/scan_range_clusterer_top.sv */
// Top level of the scan range clusterer: configuration registers and the three parts.
//
// Breakpoint segmentation of one circular lidar scan. Samples arrive in order on the
// sample channel; each one is compared with its predecessor by an exact squared
// law-of-cosines gap test, computed step by step on one shared 17x16 multiplier.
// The first sample of a scan opens the first cluster, a later sample runs the gap test
// and may then queue a closed cluster, and the final sample adds a second test against
// the first sample, after which the remaining clusters and the end marker are queued.
// Clusters go through a four-entry command queue to the back part, which applies the
// size filter and holds each result until it is transferred, so the front keeps
// working while the output is stalled as long as the queue has room; a full queue
// holds the front, and with it the sample that is queuing. Configuration writes are
// always accepted and should be made only while the block is idle.
`default_nettype none

module scan_range_clusterer_top
    import scl_pkg::*;
(
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  logic                  sample_valid,
    output logic                        sample_stall,
    input  wire  sample_t               sample,
    output logic                        result_valid,
    input  wire  logic                  result_stall,
    output result_t                     result,
    input  wire  logic                  cfg_valid,
    output logic                        cfg_ready,
    input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic fifo_push;
    cmd_t fifo_push_cmd;
    logic fifo_full;
    logic fifo_pop;
    cmd_t fifo_head;
    logic fifo_empty;

    assign cfg_ready = 1'b1;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COS_INC:  cfg_next.cos_increment_q16 = cfg_data[COS_W-1:0];
                CFG_GAP_THR:  cfg_next.gap_threshold_mm  = cfg_data[THR_W-1:0];
                CFG_MIN_SIZE: cfg_next.min_cluster_size  = cfg_data[LEN_W-1:0];
                CFG_MAX_SIZE: cfg_next.max_cluster_size  = cfg_data[LEN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_increment_q16 <= COS_INC_RST;
            cfg_reg.gap_threshold_mm  <= GAP_THR_RST;
            cfg_reg.min_cluster_size  <= MIN_SIZE_RST;
            cfg_reg.max_cluster_size  <= MAX_SIZE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (fifo_push),
        .push_cmd     (fifo_push_cmd),
        .fifo_full    (fifo_full)
    );

    scl_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_push_cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_head),
        .empty     (fifo_empty)
    );

    scl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fifo_empty   (fifo_empty),
        .head         (fifo_head),
        .pop          (fifo_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
